### rtl/sift_pkg.sv
// Shared types, constants and codes for the stuffed information frame transmitter.
package sift_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] STUFF_FLAG = 8'h5e;
    localparam logic [7:0] STUFF_ESC  = 8'h5d;

    localparam logic [2:0] REG_FLAG       = 3'd0;
    localparam logic [2:0] REG_ESCAPE     = 3'd1;
    localparam logic [2:0] REG_ADDRESS    = 3'd2;
    localparam logic [2:0] REG_CTRL_SEQ0  = 3'd3;
    localparam logic [2:0] REG_CTRL_SEQ1  = 3'd4;
    localparam logic [2:0] REG_READY_ZERO = 3'd5;
    localparam logic [2:0] REG_READY_ONE  = 3'd6;

    localparam logic [7:0] RST_FLAG       = 8'h7e;
    localparam logic [7:0] RST_ESCAPE     = 8'h7d;
    localparam logic [7:0] RST_ADDRESS    = 8'h03;
    localparam logic [7:0] RST_CTRL_SEQ0  = 8'h00;
    localparam logic [7:0] RST_CTRL_SEQ1  = 8'h40;
    localparam logic [7:0] RST_READY_ZERO = 8'h05;
    localparam logic [7:0] RST_READY_ONE  = 8'h85;

    localparam logic MODE_PAYLOAD = 1'b0;
    localparam logic MODE_REPLY   = 1'b1;

    typedef struct packed {
        logic [7:0] flag;
        logic [7:0] escape;
        logic [7:0] address;
        logic [7:0] ctrl_seq0;
        logic [7:0] ctrl_seq1;
        logic [7:0] ready_zero;
        logic [7:0] ready_one;
    } cfg_t;

    typedef struct packed {
        logic       is_ack;
        logic       ack_ok;
        logic [7:0] data;
        logic       header;
        logic [7:0] ctrl;
        logic       last;
        logic [7:0] check;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_START,
        ST_HDR_FLAG,
        ST_HDR_ADDR,
        ST_HDR_CTRL,
        ST_HDR_XOR,
        ST_DATA,
        ST_DATA_STUFF,
        ST_CHK,
        ST_CHK_STUFF,
        ST_CLOSE,
        ST_ACK
    } step_t;

endpackage

### rtl/sift_front.sv
// Front end: accepts input transactions, tracks framing state and issues commands.
module sift_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  sift_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_mode,
    input  logic [7:0]        in_data,
    input  logic              in_last,
    output logic              push,
    output sift_pkg::cmd_t    push_cmd,
    input  logic              queue_full
);

    logic       seq_reg, seq_next;
    logic       inside_reg, inside_next;
    logic [7:0] chk_reg, chk_next;
    logic [7:0] acc;
    logic [7:0] want;
    logic       ok;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    assign acc  = (inside_reg ? chk_reg : 8'h00) ^ in_data;
    assign want = seq_reg ? cfg.ready_zero : cfg.ready_one;
    assign ok   = (in_data == want);

    always_comb begin
        push_cmd.is_ack = (in_mode == sift_pkg::MODE_REPLY);
        push_cmd.ack_ok = ok;
        push_cmd.data   = in_data;
        push_cmd.header = !inside_reg;
        push_cmd.ctrl   = seq_reg ? cfg.ctrl_seq1 : cfg.ctrl_seq0;
        push_cmd.last   = in_last;
        push_cmd.check  = acc;
    end

    always_comb begin
        seq_next    = seq_reg;
        inside_next = inside_reg;
        chk_next    = chk_reg;
        if (push) begin
            if (in_mode == sift_pkg::MODE_REPLY) begin
                seq_next = seq_reg ^ ok;
            end else if (in_last) begin
                inside_next = 1'b0;
                chk_next    = 8'h00;
            end else begin
                inside_next = 1'b1;
                chk_next    = acc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg    <= 1'b0;
            inside_reg <= 1'b0;
            chk_reg    <= 8'h00;
        end else begin
            seq_reg    <= seq_next;
            inside_reg <= inside_next;
            chk_reg    <= chk_next;
        end
    end

endmodule

### rtl/sift_queue.sv
// Short command queue between the front end and the byte sequencer.
module sift_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sift_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output sift_pkg::cmd_t head_cmd
);

    sift_pkg::cmd_t                    entry_reg [sift_pkg::QUEUE_DEPTH];
    logic [sift_pkg::QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [sift_pkg::QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [sift_pkg::QUEUE_CW-1:0]     count_reg, count_next;

    localparam logic [sift_pkg::QUEUE_CW-1:0] DEPTH_C = sift_pkg::QUEUE_CW'(sift_pkg::QUEUE_DEPTH);
    localparam logic [sift_pkg::QUEUE_AW-1:0] LAST_PTR =
        sift_pkg::QUEUE_AW'(sift_pkg::QUEUE_DEPTH - 1);

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push lost");
`endif

endmodule

### rtl/sift_back.sv
// Byte sequencer: expands queued commands into line bytes and ack reports.
module sift_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  sift_pkg::cfg_t cfg,
    input  logic           head_valid,
    input  sift_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic [2:0]     m_tuser,
    output logic           m_tlast
);

    sift_pkg::step_t state_reg, state_next;
    sift_pkg::step_t step;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic [2:0] user_reg;
    logic       last_reg;

    logic       fire;
    logic       data_stuff, chk_stuff;
    logic [7:0] data_code, chk_code;
    logic [7:0] emit_byte;
    logic       emit_line, emit_fend, emit_ack, emit_last;

    assign fire = head_valid && (!valid_reg || m_tready);

    assign data_stuff = (head_cmd.data == cfg.flag) || (head_cmd.data == cfg.escape);
    assign chk_stuff  = (head_cmd.check == cfg.flag) || (head_cmd.check == cfg.escape);
    assign data_code  = (head_cmd.data == cfg.flag) ? sift_pkg::STUFF_FLAG : sift_pkg::STUFF_ESC;
    assign chk_code   = (head_cmd.check == cfg.flag) ? sift_pkg::STUFF_FLAG : sift_pkg::STUFF_ESC;

    always_comb begin
        if (state_reg != sift_pkg::ST_START) begin
            step = state_reg;
        end else if (head_cmd.is_ack) begin
            step = sift_pkg::ST_ACK;
        end else if (head_cmd.header) begin
            step = sift_pkg::ST_HDR_FLAG;
        end else begin
            step = sift_pkg::ST_DATA;
        end
    end

    // next step
    always_comb begin
        state_next = state_reg;
        if (fire) begin
            unique case (step)
                sift_pkg::ST_HDR_FLAG:   state_next = sift_pkg::ST_HDR_ADDR;
                sift_pkg::ST_HDR_ADDR:   state_next = sift_pkg::ST_HDR_CTRL;
                sift_pkg::ST_HDR_CTRL:   state_next = sift_pkg::ST_HDR_XOR;
                sift_pkg::ST_HDR_XOR:    state_next = sift_pkg::ST_DATA;
                sift_pkg::ST_DATA: begin
                    if (data_stuff) begin
                        state_next = sift_pkg::ST_DATA_STUFF;
                    end else begin
                        state_next = head_cmd.last ? sift_pkg::ST_CHK : sift_pkg::ST_START;
                    end
                end
                sift_pkg::ST_DATA_STUFF:
                    state_next = head_cmd.last ? sift_pkg::ST_CHK : sift_pkg::ST_START;
                sift_pkg::ST_CHK:
                    state_next = chk_stuff ? sift_pkg::ST_CHK_STUFF : sift_pkg::ST_CLOSE;
                sift_pkg::ST_CHK_STUFF:  state_next = sift_pkg::ST_CLOSE;
                default:                 state_next = sift_pkg::ST_START;
            endcase
        end
    end

    // byte and flags for the current step
    always_comb begin
        emit_byte = head_cmd.data;
        emit_line = 1'b1;
        emit_fend = 1'b0;
        emit_ack  = 1'b0;
        emit_last = 1'b0;
        unique case (step)
            sift_pkg::ST_HDR_FLAG:   emit_byte = cfg.flag;
            sift_pkg::ST_HDR_ADDR:   emit_byte = cfg.address;
            sift_pkg::ST_HDR_CTRL:   emit_byte = head_cmd.ctrl;
            sift_pkg::ST_HDR_XOR:    emit_byte = cfg.address ^ head_cmd.ctrl;
            sift_pkg::ST_DATA: begin
                emit_byte = data_stuff ? cfg.escape : head_cmd.data;
                emit_last = !data_stuff && !head_cmd.last;
            end
            sift_pkg::ST_DATA_STUFF: begin
                emit_byte = data_code;
                emit_last = !head_cmd.last;
            end
            sift_pkg::ST_CHK:        emit_byte = chk_stuff ? cfg.escape : head_cmd.check;
            sift_pkg::ST_CHK_STUFF:  emit_byte = chk_code;
            sift_pkg::ST_CLOSE: begin
                emit_byte = cfg.flag;
                emit_fend = 1'b1;
                emit_last = 1'b1;
            end
            sift_pkg::ST_ACK: begin
                emit_byte = head_cmd.data;
                emit_line = 1'b0;
                emit_ack  = head_cmd.ack_ok;
                emit_last = 1'b1;
            end
            default: emit_byte = head_cmd.data;
        endcase
    end

    assign pop        = fire && emit_last;
    assign valid_next = fire || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (fire) begin
            byte_reg <= emit_byte;
            user_reg <= {emit_ack, emit_fend, emit_line};
            last_reg <= emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sift_pkg::ST_START;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

### rtl/stuffed_info_frame_transmitter.sv
// Top level of the stuffed information frame transmitter.
//
// Input stream s_*: s_tdata holds a payload byte or a received reply control
// byte, s_tuser[0] is the mode (0 payload, 1 reply), s_tlast marks the final
// payload byte of a frame. Output stream m_*: one line byte or ack report per
// transaction; m_tlast marks the last result caused by an input transaction.
// Configuration channel cfg_*: index 0..6 selects flag, escape, address,
// control for sequence 0 and 1, receive-ready zero and one; write only idle.
// The first result of an input is registered in the command queue and then in the
// output register before it is presented on m_tvalid.
// Throughput: the sequencer emits one byte per cycle while the receiver takes
// them; an input yields 1 to 9 results (header, stuffing, check byte and closing flag).
// A four-entry command queue lets the input side accept one transaction per
// cycle while the sequencer works or the receiver stalls; when it is full,
// s_tready drops. A stalled output holds its data until taken.
// Reset clears framing state, sequence bit, queue and output valid, and
// restores the default register values.
module stuffed_info_frame_transmitter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [0:0] s_tuser,   // [0] mode
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [0] is_line_byte, [1] frame_end, [2] ack_accepted
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    sift_pkg::cfg_t cfg_reg, cfg_next;
    sift_pkg::cmd_t push_cmd, head_cmd;
    logic           push, pop, queue_full, head_valid;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                sift_pkg::REG_FLAG:       cfg_next.flag       = cfg_data;
                sift_pkg::REG_ESCAPE:     cfg_next.escape     = cfg_data;
                sift_pkg::REG_ADDRESS:    cfg_next.address    = cfg_data;
                sift_pkg::REG_CTRL_SEQ0:  cfg_next.ctrl_seq0  = cfg_data;
                sift_pkg::REG_CTRL_SEQ1:  cfg_next.ctrl_seq1  = cfg_data;
                sift_pkg::REG_READY_ZERO: cfg_next.ready_zero = cfg_data;
                sift_pkg::REG_READY_ONE:  cfg_next.ready_one  = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag       <= sift_pkg::RST_FLAG;
            cfg_reg.escape     <= sift_pkg::RST_ESCAPE;
            cfg_reg.address    <= sift_pkg::RST_ADDRESS;
            cfg_reg.ctrl_seq0  <= sift_pkg::RST_CTRL_SEQ0;
            cfg_reg.ctrl_seq1  <= sift_pkg::RST_CTRL_SEQ1;
            cfg_reg.ready_zero <= sift_pkg::RST_READY_ZERO;
            cfg_reg.ready_one  <= sift_pkg::RST_READY_ONE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sift_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser[0]),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    sift_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    sift_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

`ifndef SYNTHESIS
    a_fend_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tuser[0] && m_tlast))
        else $error("closing flag without line byte or run end");

    a_ack_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && !m_tuser[1]))
        else $error("ack report not a single result");

    a_ack_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> !m_tuser[0])
        else $error("ack accepted on a line byte");
`endif

endmodule

### bench/testbench.sv
// Self-checking bench for the stuffed information frame transmitter.
`timescale 1ns / 100ps

module testbench;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int IDLE_PERCENT   = 18;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_ITEMS    = 48;
    localparam int NUM_PHASES     = 5;
    localparam int NUM_ROWS       = 22;

    localparam logic [2:0] NO_REG = sift_pkg::REG_FLAG;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_line_byte;
        logic       frame_end;
        logic       ack_accepted;
        logic       run_last;
    } line_result_t;

    typedef enum logic [1:0] {
        ROW_PAYLOAD,
        ROW_REPLY,
        ROW_REGISTER
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [2:0] reg_index;
        logic [7:0] value;
        logic       last;
        logic       ack;
    } row_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = '0;
    logic [0:0] s_tuser   = '0;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    sift_pkg::cfg_t line_cfg;
    logic           seq_bit;
    logic [7:0]     check_acc;
    logic           in_frame;
    line_result_t   expected_bytes [$];

    bit calm         = 1'b0;
    bit hold_off_req = 1'b0;
    int fail_count    = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int frames_closed = 0;
    int acks_taken    = 0;
    int reg_writes    = 0;
    int quiet_cycles  = 0;

    row_t directed_rows [0:NUM_ROWS-1] = '{
        '{ROW_REPLY,    NO_REG,               8'h85, 1'b0, 1'b1},
        '{ROW_REPLY,    NO_REG,               8'h85, 1'b0, 1'b0},
        '{ROW_REPLY,    NO_REG,               8'h05, 1'b1, 1'b1},
        '{ROW_REPLY,    NO_REG,               8'h00, 1'b0, 1'b0},
        '{ROW_REPLY,    NO_REG,               8'hff, 1'b1, 1'b0},
        '{ROW_PAYLOAD,  NO_REG,               8'h00, 1'b0, 1'b0},
        '{ROW_PAYLOAD,  NO_REG,               8'h7e, 1'b0, 1'b0},
        '{ROW_PAYLOAD,  NO_REG,               8'h7d, 1'b0, 1'b0},
        '{ROW_PAYLOAD,  NO_REG,               8'hff, 1'b1, 1'b0},
        '{ROW_PAYLOAD,  NO_REG,               8'h7e, 1'b1, 1'b0},
        '{ROW_PAYLOAD,  NO_REG,               8'h7d, 1'b1, 1'b0},
        '{ROW_REPLY,    NO_REG,               8'h85, 1'b0, 1'b1},
        '{ROW_PAYLOAD,  NO_REG,               8'h01, 1'b0, 1'b0},
        '{ROW_REPLY,    NO_REG,               8'h05, 1'b0, 1'b1},
        '{ROW_REPLY,    NO_REG,               8'h05, 1'b0, 1'b0},
        '{ROW_PAYLOAD,  NO_REG,               8'h80, 1'b1, 1'b0},
        '{ROW_PAYLOAD,  NO_REG,               8'h00, 1'b1, 1'b0},
        '{ROW_REGISTER, sift_pkg::REG_FLAG,   8'h42, 1'b0, 1'b0},
        '{ROW_REGISTER, sift_pkg::REG_ESCAPE, 8'h42, 1'b0, 1'b0},
        '{ROW_PAYLOAD,  NO_REG,               8'h42, 1'b1, 1'b0},
        '{ROW_PAYLOAD,  NO_REG,               8'h5e, 1'b0, 1'b0},
        '{ROW_PAYLOAD,  NO_REG,               8'h1c, 1'b1, 1'b0}
    };

    stuffed_info_frame_transmitter i_dut (.*);

    always #HALF_PERIOD aclk = ~aclk;

    task automatic push_byte(input logic [7:0] b, input logic line, input logic fend,
                             input logic ack);
        line_result_t r;
        r = '{b, line, fend, ack, 1'b0};
        expected_bytes.push_back(r);
    endtask

    task automatic push_stuffed(input logic [7:0] b);
        if (b == line_cfg.flag) begin
            push_byte(line_cfg.escape, 1'b1, 1'b0, 1'b0);
            push_byte(sift_pkg::STUFF_FLAG, 1'b1, 1'b0, 1'b0);
        end else if (b == line_cfg.escape) begin
            push_byte(line_cfg.escape, 1'b1, 1'b0, 1'b0);
            push_byte(sift_pkg::STUFF_ESC, 1'b1, 1'b0, 1'b0);
        end else begin
            push_byte(b, 1'b1, 1'b0, 1'b0);
        end
    endtask

    task automatic predict_transaction(input logic mode, input logic [7:0] data,
                                       input logic last);
        logic [7:0]   want;
        logic [7:0]   ctrl;
        logic         ok;
        line_result_t tail;
        if (mode == sift_pkg::MODE_REPLY) begin
            want = seq_bit ? line_cfg.ready_zero : line_cfg.ready_one;
            ok   = (data == want);
            if (ok) seq_bit = ~seq_bit;
            push_byte(data, 1'b0, 1'b0, ok);
        end else begin
            if (!in_frame) begin
                ctrl = seq_bit ? line_cfg.ctrl_seq1 : line_cfg.ctrl_seq0;
                push_byte(line_cfg.flag, 1'b1, 1'b0, 1'b0);
                push_byte(line_cfg.address, 1'b1, 1'b0, 1'b0);
                push_byte(ctrl, 1'b1, 1'b0, 1'b0);
                push_byte(line_cfg.address ^ ctrl, 1'b1, 1'b0, 1'b0);
                in_frame  = 1'b1;
                check_acc = '0;
            end
            check_acc = check_acc ^ data;
            push_stuffed(data);
            if (last) begin
                push_stuffed(check_acc);
                push_byte(line_cfg.flag, 1'b1, 1'b1, 1'b0);
                in_frame  = 1'b0;
                check_acc = '0;
            end
        end
        tail = expected_bytes.pop_back();
        tail.run_last = 1'b1;
        expected_bytes.push_back(tail);
    endtask

    task automatic offer_item(input logic mode, input logic [7:0] data, input logic last,
                              input bit typed, input logic exp_ack);
        line_result_t typed_res;
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_transaction(mode, data, last);
        if (typed) begin
            void'(expected_bytes.pop_back());
            typed_res = '{data, 1'b0, 1'b0, exp_ack, 1'b1};
            expected_bytes.push_back(typed_res);
        end
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            sift_pkg::REG_FLAG:       line_cfg.flag       = value;
            sift_pkg::REG_ESCAPE:     line_cfg.escape     = value;
            sift_pkg::REG_ADDRESS:    line_cfg.address    = value;
            sift_pkg::REG_CTRL_SEQ0:  line_cfg.ctrl_seq0  = value;
            sift_pkg::REG_CTRL_SEQ1:  line_cfg.ctrl_seq1  = value;
            sift_pkg::REG_READY_ZERO: line_cfg.ready_zero = value;
            sift_pkg::REG_READY_ONE:  line_cfg.ready_one  = value;
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_payload();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15) return line_cfg.flag;
        if (roll < 30) return line_cfg.escape;
        if (roll < 35) return 8'h00;
        if (roll < 40) return 8'hff;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_reply();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50) return seq_bit ? line_cfg.ready_zero : line_cfg.ready_one;
        if (roll < 70) return seq_bit ? line_cfg.ready_one : line_cfg.ready_zero;
        return 8'($urandom);
    endfunction

    task automatic run_traffic(input int count);
        int sent;
        int len;
        int roll;
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(99);
            if (roll < 20) begin
                offer_item(sift_pkg::MODE_REPLY, pick_reply(), 1'($urandom), 1'b0, 1'b0);
                sent++;
            end else if (roll < 28) begin
                offer_item(sift_pkg::MODE_PAYLOAD, 8'($urandom), 1'($urandom), 1'b0, 1'b0);
                sent++;
            end else begin
                len = $urandom_range(6, 1);
                for (int k = 1; k <= len; k++) begin
                    if ($urandom_range(99) < 10) begin
                        offer_item(sift_pkg::MODE_REPLY, pick_reply(), 1'($urandom),
                                   1'b0, 1'b0);
                        sent++;
                    end
                    offer_item(sift_pkg::MODE_PAYLOAD, pick_payload(), k == len,
                               1'b0, 1'b0);
                end
                sent += len;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(negedge aclk) begin
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge aclk);
        end
        m_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge aclk) begin : result_check
        line_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_bytes.size() == 0) begin
                $error("out_byte: expected nothing, got %h", m_tdata);
                fail_count++;
            end else begin
                want = expected_bytes.pop_front();
                check_field("out_byte", want.out_byte, m_tdata);
                check_field("is_line_byte", 8'(want.is_line_byte), 8'(m_tuser[0]));
                check_field("frame_end", 8'(want.frame_end), 8'(m_tuser[1]));
                check_field("ack_accepted", 8'(want.ack_accepted), 8'(m_tuser[2]));
                check_field("run_last", 8'(want.run_last), 8'(m_tlast));
                if (want.frame_end) frames_closed++;
                if (want.ack_accepted) acks_taken++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: %0d cycles without a transaction", quiet_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        sift_pkg::cfg_t setting;
        logic [55:0]    raw;
        line_cfg  = '{sift_pkg::RST_FLAG, sift_pkg::RST_ESCAPE, sift_pkg::RST_ADDRESS,
                      sift_pkg::RST_CTRL_SEQ0, sift_pkg::RST_CTRL_SEQ1,
                      sift_pkg::RST_READY_ZERO, sift_pkg::RST_READY_ONE};
        seq_bit   = 1'b0;
        check_acc = '0;
        in_frame  = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_REGISTER: begin
                    settle();
                    write_reg(directed_rows[i].reg_index, directed_rows[i].value);
                end
                ROW_REPLY: begin
                    offer_item(sift_pkg::MODE_REPLY, directed_rows[i].value,
                               directed_rows[i].last, 1'b1, directed_rows[i].ack);
                end
                default: begin
                    offer_item(sift_pkg::MODE_PAYLOAD, directed_rows[i].value,
                               directed_rows[i].last, 1'b0, 1'b0);
                end
            endcase
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            raw = {$urandom, 24'($urandom)};
            case (phase)
                0:       setting = '0;
                1:       setting = '1;
                2:       setting = '{sift_pkg::RST_FLAG, sift_pkg::RST_ESCAPE,
                                     sift_pkg::RST_ADDRESS, sift_pkg::RST_CTRL_SEQ0,
                                     sift_pkg::RST_CTRL_SEQ1, sift_pkg::RST_READY_ZERO,
                                     sift_pkg::RST_READY_ONE};
                default: setting = raw;
            endcase
            if (phase == NUM_PHASES - 1) setting.escape = setting.flag;
            write_reg(sift_pkg::REG_FLAG, setting.flag);
            write_reg(sift_pkg::REG_ESCAPE, setting.escape);
            write_reg(sift_pkg::REG_ADDRESS, setting.address);
            write_reg(sift_pkg::REG_CTRL_SEQ0, setting.ctrl_seq0);
            write_reg(sift_pkg::REG_CTRL_SEQ1, setting.ctrl_seq1);
            write_reg(sift_pkg::REG_READY_ZERO, setting.ready_zero);
            write_reg(sift_pkg::REG_READY_ONE, setting.ready_one);
            calm         = (phase == 1);
            hold_off_req = (phase == 2);
            run_traffic(PHASE_ITEMS);
        end
        calm = 1'b0;
        settle();

        if (expected_bytes.size() != 0) begin
            $error("out_byte: %0d results still expected", expected_bytes.size());
            fail_count++;
        end
        $display("Covered %0d input transactions, %0d results, %0d closed frames,",
                 items_sent, results_seen, frames_closed);
        $display("%0d accepted replies and %0d register writes across the reset values",
                 acks_taken, reg_writes);
        $display("and the written settings, including flag equal to escape.");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
rtl/sift_pkg.sv
rtl/sift_front.sv
rtl/sift_queue.sv
rtl/sift_back.sv
rtl/stuffed_info_frame_transmitter.sv
bench/testbench.sv
